// ===== rtl/multitouch_slot_frame_tracker_assert.svh =====
// Assertion macros used by the checker file of the slot frame tracker.
// Depends on signals i_clk and i_rst_n in the scope of use.
`ifndef MULTITOUCH_SLOT_FRAME_TRACKER_ASSERT_SVH
`define MULTITOUCH_SLOT_FRAME_TRACKER_ASSERT_SVH

// Implication checked on the same edge.
`define MTSF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mtsf check failed");

// Implication checked on the following edge.
`define MTSF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mtsf check failed");

`endif

// ===== rtl/mtsf_pkg.sv =====
// Shared codes for the multitouch slot frame tracker.
// No dependencies; used by the top level and its checker.
package mtsf_pkg;
    localparam int SLOT_W = 4;
    localparam int QDEPTH = 16;
    localparam int QAW    = 4;
    localparam int CNT_W  = 5;

    localparam logic [3:0] K_FRAME = 4'd0;
    localparam logic [3:0] K_SLOT  = 4'd1;
    localparam logic [3:0] K_ID    = 4'd2;
    localparam logic [3:0] K_X     = 4'd3;
    localparam logic [3:0] K_Y     = 4'd4;
    localparam logic [3:0] K_MAJ   = 4'd5;
    localparam logic [3:0] K_MIN   = 4'd6;
    localparam logic [3:0] K_PRS   = 4'd7;

    localparam logic [1:0] TK_DOWN = 2'd0;
    localparam logic [1:0] TK_MOVE = 2'd1;
    localparam logic [1:0] TK_UP   = 2'd2;
endpackage

// ===== rtl/mtsf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mtsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/multitouch_slot_frame_tracker.sv =====
// Multitouch slot frame tracker: top level with slot memory and queues.
// Depends on mtsf_pkg and mtsf_ram.
//
// Takes one decoded touch event per input word (tuser = kind, tdata = value)
// and keeps per-slot id, X, Y, major, minor and pressure in a slot RAM, plus
// down and up queues of 16 entries in two small RAMs. Slot select and ignored
// kinds are handled in the idle state; a slot update also passes through S_EVW
// (RAM read, then modify and write back). A frame end walks the down queue
// (scan, queue read, result per down), the move flags (a scan per slot, a
// result per flagged slot) and the up queue (scan, queue read, result per
// up), with a scan step at each of the three phase changes, then flushes and
// clears; output stalls hold the scan and the flush. One result is held back
// so the final one can carry tlast. Output words wait in an output register
// while new events are accepted. Slot records read as empty until first
// written, through per-slot valid bits.
module multitouch_slot_frame_tracker #(
    parameter int SLOTS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_wdata,   // axis_present
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,  // [31:0] event_value
    input  logic [3:0]   s_axis_tuser,  // [3:0] kind
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [3:0] slot_index, [20:4] contact_id, [36:21] pos_x, [52:37] pos_y,
    // [68:53] major_axis, [84:69] minor_axis, [100:85] contact_pressure,
    // [101] queue_dropped, [103:102] zero
    output logic [103:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser,  // [1:0] touch_kind
    output logic         m_axis_tlast   // frame_last
);
    localparam int AW = $clog2(SLOTS);
    localparam int CW = mtsf_pkg::CNT_W;
    localparam logic [CW-1:0] SLOTS_L = CW'(SLOTS);
    localparam logic [CW-1:0] QFULL   = CW'(mtsf_pkg::QDEPTH);

    typedef struct packed {
        logic [15:0] prs;
        logic [15:0] mnr;
        logic [15:0] maj;
        logic [15:0] y;
        logic [15:0] x;
        logic [16:0] id;
    } t_rec;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  slot;
        logic [16:0] id;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] maj;
        logic [15:0] mnr;
        logic [15:0] prs;
        logic        drop;
    } t_res;

    typedef enum logic [2:0] {S_IDLE, S_EVW, S_FSCAN, S_FQ, S_FR, S_FLUSH} t_state;

    localparam t_rec REC_EMPTY = '{id: '1, default: '0};

    t_state          r_state;
    logic [1:0]      r_ph;
    logic [CW-1:0]   r_idx;
    logic [AW-1:0]   r_slot;
    logic [AW-1:0]   r_cur;
    logic [AW-1:0]   r_raddr;
    logic [3:0]      r_kind;
    logic [31:0]     r_val;
    logic [SLOTS-1:0] r_vld;
    logic [SLOTS-1:0] r_move;
    logic [CW-1:0]   r_dcnt;
    logic [CW-1:0]   r_ucnt;
    logic            r_drop;
    logic [2:0]      r_axis;
    logic            r_pend_v;
    t_res            r_pend;
    logic            r_out_v;
    logic            r_out_last;
    t_res            r_out;

    logic [AW-1:0]   ram_raddr;
    logic [$bits(t_rec)-1:0] ram_rdata;
    t_rec            rec;
    t_rec            n_rec;
    logic            slot_we;
    logic [AW-1:0]   dq_rdata;
    logic [AW-1:0]   uq_rdata;
    logic [AW-1:0]   q_slot;
    logic            dq_we;
    logic            uq_we;
    logic            rec_active;
    logic [15:0]     val_sat;
    logic            room;
    t_res            res;
    logic            emit;
    logic [AW-1:0]   slot_clamp;

    // Saturate the event value to 0..65535.
    assign val_sat = r_val[31] ? 16'd0 : ((|r_val[31:16]) ? 16'hFFFF : r_val[15:0]);

    // Clamp a slot select to the slot range.
    always_comb begin
        if (s_axis_tdata[31]) begin
            slot_clamp = '0;
        end else if (s_axis_tdata > 32'(SLOTS - 1)) begin
            slot_clamp = AW'(SLOTS - 1);
        end else begin
            slot_clamp = s_axis_tdata[AW-1:0];
        end
    end

    assign q_slot = (r_ph == mtsf_pkg::TK_UP) ? uq_rdata : dq_rdata;

    always_comb begin
        case (r_state)
            S_IDLE:  ram_raddr = r_slot;
            S_FSCAN: ram_raddr = r_idx[AW-1:0];
            S_FQ:    ram_raddr = q_slot;
            default: ram_raddr = r_cur;
        endcase
    end

    // Unwritten slots read as empty.
    assign rec        = r_vld[r_raddr] ? t_rec'(ram_rdata) : REC_EMPTY;
    assign rec_active = !rec.id[16];

    // Modify step of a slot update.
    always_comb begin
        n_rec = rec;
        dq_we = 1'b0;
        uq_we = 1'b0;
        case (r_kind)
            mtsf_pkg::K_ID: begin
                if (!r_val[31]) begin
                    n_rec.id = {1'b0, val_sat};
                    dq_we    = !rec_active && (r_dcnt < QFULL);
                end else begin
                    n_rec.id = '1;
                    uq_we    = rec_active && (r_ucnt < QFULL);
                end
            end
            mtsf_pkg::K_X: n_rec.x = val_sat;
            mtsf_pkg::K_Y: n_rec.y = val_sat;
            mtsf_pkg::K_MAJ: if (r_axis[0]) n_rec.maj = val_sat;
            mtsf_pkg::K_MIN: if (r_axis[1]) n_rec.mnr = val_sat;
            mtsf_pkg::K_PRS: if (r_axis[2]) n_rec.prs = val_sat;
            default: ;
        endcase
        if (r_state != S_EVW) begin
            dq_we = 1'b0;
            uq_we = 1'b0;
        end
    end

    assign slot_we = (r_state == S_EVW);

    // Result formed from the slot record in the read-data cycle.
    always_comb begin
        res.kind = r_ph;
        res.slot = mtsf_pkg::SLOT_W'(r_cur);
        res.x    = rec.x;
        res.y    = rec.y;
        res.drop = r_drop;
        if (r_ph == mtsf_pkg::TK_UP) begin
            res.id  = '1;
            res.maj = '0;
            res.mnr = '0;
            res.prs = '0;
        end else begin
            res.id  = rec.id;
            res.maj = rec.maj;
            res.mnr = rec.mnr;
            res.prs = rec.prs;
        end
    end

    assign emit = !((r_ph == mtsf_pkg::TK_MOVE) && rec.id[16]);
    // A held result can only be pushed while the output register is free.
    assign room = !r_pend_v || !r_out_v;

    always_ff @(posedge i_clk) begin
        r_raddr <= ram_raddr;
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ph       <= mtsf_pkg::TK_DOWN;
            r_idx      <= '0;
            r_slot     <= '0;
            r_cur      <= '0;
            r_vld      <= '0;
            r_move     <= '0;
            r_dcnt     <= '0;
            r_ucnt     <= '0;
            r_drop     <= 1'b0;
            r_axis     <= 3'd7;
            r_pend_v   <= 1'b0;
            r_out_v    <= 1'b0;
            r_out_last <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_axis <= i_cfg_wdata;
            end
            // Free the output register unless the flush refills it on this edge.
            if (r_out_v && m_axis_tready && !(r_state == S_FLUSH && r_pend_v)) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_kind <= s_axis_tuser;
                        r_val  <= s_axis_tdata;
                        r_cur  <= r_slot;
                        case (s_axis_tuser)
                            mtsf_pkg::K_FRAME: begin
                                r_ph    <= mtsf_pkg::TK_DOWN;
                                r_idx   <= '0;
                                r_state <= S_FSCAN;
                            end
                            mtsf_pkg::K_SLOT: r_slot <= slot_clamp;
                            mtsf_pkg::K_ID, mtsf_pkg::K_X, mtsf_pkg::K_Y, mtsf_pkg::K_MAJ,
                            mtsf_pkg::K_MIN, mtsf_pkg::K_PRS: r_state <= S_EVW;
                            default: ;
                        endcase
                    end
                end
                S_EVW: begin
                    r_vld[r_cur] <= 1'b1;
                    if (dq_we) begin
                        r_dcnt <= r_dcnt + 1'b1;
                    end
                    if (uq_we) begin
                        r_ucnt <= r_ucnt + 1'b1;
                    end
                    if (r_kind == mtsf_pkg::K_ID && !dq_we && !uq_we &&
                        (r_val[31] ? rec_active : !rec_active)) begin
                        r_drop <= 1'b1;
                    end
                    if ((r_kind == mtsf_pkg::K_X || r_kind == mtsf_pkg::K_Y) && rec_active) begin
                        r_move[r_cur] <= 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                S_FSCAN: begin
                    if (room) begin
                        case (r_ph)
                            mtsf_pkg::TK_DOWN: begin
                                if (r_idx < r_dcnt) begin
                                    r_state <= S_FQ;
                                end else begin
                                    r_ph  <= mtsf_pkg::TK_MOVE;
                                    r_idx <= '0;
                                end
                            end
                            mtsf_pkg::TK_MOVE: begin
                                if (r_idx < SLOTS_L) begin
                                    if (r_move[r_idx[AW-1:0]]) begin
                                        r_cur   <= r_idx[AW-1:0];
                                        r_state <= S_FR;
                                    end else begin
                                        r_idx <= r_idx + 1'b1;
                                    end
                                end else begin
                                    r_ph  <= mtsf_pkg::TK_UP;
                                    r_idx <= '0;
                                end
                            end
                            default: begin
                                if (r_idx < r_ucnt) begin
                                    r_state <= S_FQ;
                                end else begin
                                    r_state <= S_FLUSH;
                                end
                            end
                        endcase
                    end
                end
                S_FQ: begin
                    r_cur   <= q_slot;
                    r_state <= S_FR;
                end
                S_FR: begin
                    if (emit) begin
                        if (r_pend_v) begin
                            r_out      <= r_pend;
                            r_out_last <= 1'b0;
                            r_out_v    <= 1'b1;
                        end
                        r_pend   <= res;
                        r_pend_v <= 1'b1;
                    end
                    r_idx   <= r_idx + 1'b1;
                    r_state <= S_FSCAN;
                end
                S_FLUSH: begin
                    if (!r_pend_v || !r_out_v || m_axis_tready) begin
                        if (r_pend_v) begin
                            r_out      <= r_pend;
                            r_out_last <= 1'b1;
                            r_out_v    <= 1'b1;
                            r_pend_v   <= 1'b0;
                        end
                        r_dcnt  <= '0;
                        r_ucnt  <= '0;
                        r_move  <= '0;
                        r_drop  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    mtsf_ram #(.WIDTH($bits(t_rec)), .DEPTH(SLOTS)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (r_cur),
        .i_wdata (n_rec),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    mtsf_ram #(.WIDTH(AW), .DEPTH(mtsf_pkg::QDEPTH)) u_down_q (
        .i_clk   (i_clk),
        .i_we    (dq_we),
        .i_waddr (r_dcnt[mtsf_pkg::QAW-1:0]),
        .i_wdata (r_cur),
        .i_raddr (r_idx[mtsf_pkg::QAW-1:0]),
        .o_rdata (dq_rdata)
    );

    mtsf_ram #(.WIDTH(AW), .DEPTH(mtsf_pkg::QDEPTH)) u_up_q (
        .i_clk   (i_clk),
        .i_we    (uq_we),
        .i_waddr (r_ucnt[mtsf_pkg::QAW-1:0]),
        .i_wdata (r_cur),
        .i_raddr (r_idx[mtsf_pkg::QAW-1:0]),
        .o_rdata (uq_rdata)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {2'b00, r_out.drop, r_out.prs, r_out.mnr, r_out.maj,
                            r_out.y, r_out.x, r_out.id, r_out.slot};
endmodule

// ===== rtl/mtsf_checker.sv =====
// Port-level checker for the slot frame tracker, bound to the top level.
// Depends on mtsf_pkg and multitouch_slot_frame_tracker_assert.svh.
`include "multitouch_slot_frame_tracker_assert.svh"

module mtsf_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [3:0]   s_axis_tuser,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [103:0] m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);
    // Hold a stalled output word.
    `MTSF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    // Drain a frame before taking the next word.
    `MTSF_ASSERT_NEXT(a_frame_busy, s_axis_tvalid && s_axis_tready && s_axis_tuser == mtsf_pkg::K_FRAME, !s_axis_tready)
    // An up carries id -1 and a zero contact shape.
    `MTSF_ASSERT_NOW(a_up_shape, m_axis_tvalid && m_axis_tuser == mtsf_pkg::TK_UP, m_axis_tdata[20:4] == 17'h1FFFF && m_axis_tdata[100:53] == 48'd0)
endmodule

bind multitouch_slot_frame_tracker mtsf_checker u_mtsf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== bench/multitouch_slot_frame_tracker_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for multitouch_slot_frame_tracker: random and directed slot events,
// a scoreboard class that predicts frame-end touch words, random stalls on both streams.
// Depends on mtsf_pkg and the tracker RTL.

typedef struct packed {
    logic [1:0]  touch_kind;
    logic [3:0]  slot;
    logic [16:0] contact_id;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] major_axis;
    logic [15:0] minor_axis;
    logic [15:0] pressure;
    logic        last;
    logic        dropped;
} t_touch_word;

class t_frame_scoreboard;
    logic [2:0]  axis_en;
    logic [3:0]  cur_slot;
    int          slot_id[16];
    logic [15:0] slot_x[16], slot_y[16], slot_maj[16], slot_min[16], slot_prs[16];
    logic [3:0]  land_q[$];
    logic [3:0]  lift_q[$];
    logic [15:0] moved;
    logic        dropped;
    t_touch_word pending[$];
    int          errors;
    int          words_checked;
    int          frames;

    function new();
        axis_en = 3'd7;
        cur_slot = '0;
        for (int i = 0; i < 16; i++) begin
            slot_id[i] = -1;
            slot_x[i] = '0; slot_y[i] = '0;
            slot_maj[i] = '0; slot_min[i] = '0; slot_prs[i] = '0;
        end
        moved = '0;
        dropped = 1'b0;
        errors = 0;
        words_checked = 0;
        frames = 0;
    endfunction

    function void set_axes(logic [2:0] a);
        axis_en = a;
    endfunction

    function logic [15:0] clip16(longint v);
        if (v < 0) return 16'd0;
        if (v > 65535) return 16'hFFFF;
        return v[15:0];
    endfunction

    function void queue_word(logic [1:0] k, logic [3:0] s, int id, bit shape);
        t_touch_word w;
        w.touch_kind = k;
        w.slot       = s;
        w.contact_id = id[16:0];
        w.pos_x      = slot_x[s];
        w.pos_y      = slot_y[s];
        w.major_axis = shape ? slot_maj[s] : 16'd0;
        w.minor_axis = shape ? slot_min[s] : 16'd0;
        w.pressure   = shape ? slot_prs[s] : 16'd0;
        w.last       = 1'b0;
        w.dropped    = dropped;
        pending = {pending, w};
    endfunction

    // Predict the words caused by one accepted event.
    function void note_event(logic [3:0] kind, logic signed [31:0] value);
        longint v;
        logic [3:0] s;
        bit live;
        int n;
        v = value;
        s = cur_slot;
        live = slot_id[s] >= 0;
        case (kind)
            mtsf_pkg::K_FRAME: begin
                n = pending.size();
                foreach (land_q[i])
                    queue_word(mtsf_pkg::TK_DOWN, land_q[i], slot_id[land_q[i]], 1);
                for (int i = 0; i < 16; i++)
                    if (moved[i] && slot_id[i] >= 0)
                        queue_word(mtsf_pkg::TK_MOVE, 4'(i), slot_id[i], 1);
                foreach (lift_q[i]) queue_word(mtsf_pkg::TK_UP, lift_q[i], -1, 0);
                if (pending.size() > n) pending[pending.size() - 1].last = 1'b1;
                land_q.delete();
                lift_q.delete();
                moved = '0;
                dropped = 1'b0;
                frames++;
            end
            mtsf_pkg::K_SLOT: cur_slot = (v < 0) ? 4'd0 : (v > 15) ? 4'd15 : v[3:0];
            mtsf_pkg::K_ID: begin
                if (v >= 0) begin
                    if (!live) begin
                        if (land_q.size() < mtsf_pkg::QDEPTH) land_q = {land_q, s};
                        else dropped = 1'b1;
                    end
                    slot_id[s] = clip16(v);
                end else begin
                    if (live) begin
                        if (lift_q.size() < mtsf_pkg::QDEPTH) lift_q = {lift_q, s};
                        else dropped = 1'b1;
                    end
                    slot_id[s] = -1;
                end
            end
            mtsf_pkg::K_X, mtsf_pkg::K_Y: begin
                if (kind == mtsf_pkg::K_X) slot_x[s] = clip16(v);
                else slot_y[s] = clip16(v);
                if (live) moved[s] = 1'b1;
            end
            mtsf_pkg::K_MAJ: if (axis_en[0]) slot_maj[s] = clip16(v);
            mtsf_pkg::K_MIN: if (axis_en[1]) slot_min[s] = clip16(v);
            mtsf_pkg::K_PRS: if (axis_en[2]) slot_prs[s] = clip16(v);
            default: ;
        endcase
    endfunction

    task flag_mismatch(string what);
        $display("[%0t] MISMATCH %s", $realtime, what);
        errors++;
    endtask

    task check_word(t_touch_word got);
        t_touch_word want;
        if (pending.size() == 0) begin
            flag_mismatch($sformatf("unexpected word kind=%0d slot=%0d",
                                    got.touch_kind, got.slot));
            return;
        end
        want = pending.pop_front();
        words_checked++;
        if (got.touch_kind != want.touch_kind) flag_mismatch($sformatf(
            "touch_kind got %0d want %0d", got.touch_kind, want.touch_kind));
        if (got.slot != want.slot) flag_mismatch($sformatf(
            "slot_index got %0d want %0d", got.slot, want.slot));
        if (got.contact_id != want.contact_id) flag_mismatch($sformatf(
            "contact_id got %h want %h", got.contact_id, want.contact_id));
        if (got.pos_x != want.pos_x) flag_mismatch($sformatf(
            "pos_x got %h want %h", got.pos_x, want.pos_x));
        if (got.pos_y != want.pos_y) flag_mismatch($sformatf(
            "pos_y got %h want %h", got.pos_y, want.pos_y));
        if (got.major_axis != want.major_axis) flag_mismatch($sformatf(
            "major_axis got %h want %h", got.major_axis, want.major_axis));
        if (got.minor_axis != want.minor_axis) flag_mismatch($sformatf(
            "minor_axis got %h want %h", got.minor_axis, want.minor_axis));
        if (got.pressure != want.pressure) flag_mismatch($sformatf(
            "contact_pressure got %h want %h", got.pressure, want.pressure));
        if (got.last != want.last) flag_mismatch($sformatf(
            "tlast got %0b want %0b", got.last, want.last));
        if (got.dropped != want.dropped) flag_mismatch($sformatf(
            "queue_dropped got %0b want %0b", got.dropped, want.dropped));
    endtask
endclass

module multitouch_slot_frame_tracker_test;
    localparam logic [3:0] K_IGNORED  = 4'd8;
    localparam logic [3:0] K_RESERVED = 4'd15;
    localparam int SETTLE_CYCLES = 200;
    localparam int QUIET_LIMIT   = 4000;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [2:0]   i_cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata;    // [31:0] event_value
    logic [3:0]   s_axis_tuser;    // [3:0] kind
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // [3:0] slot_index, [20:4] contact_id, [36:21] pos_x, [52:37] pos_y,
    // [68:53] major_axis, [84:69] minor_axis, [100:85] contact_pressure,
    // [101] queue_dropped, [103:102] zero
    logic [103:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;    // [1:0] touch_kind
    logic         m_axis_tlast;

    t_frame_scoreboard sb;
    int  events_sent;
    bit  steady;       // when set, neither side idles
    int  stall_left;
    int  quiet_cycles;

    multitouch_slot_frame_tracker #(.SLOTS(16)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always begin
        i_clk = 1'b0; #10;
        i_clk = 1'b1; #10;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Output side: check each accepted word, then decide the next tready.
    always @(posedge i_clk) begin
        t_touch_word got;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.touch_kind = m_axis_tuser;
                got.slot       = m_axis_tdata[3:0];
                got.contact_id = m_axis_tdata[20:4];
                got.pos_x      = m_axis_tdata[36:21];
                got.pos_y      = m_axis_tdata[52:37];
                got.major_axis = m_axis_tdata[68:53];
                got.minor_axis = m_axis_tdata[84:69];
                got.pressure   = m_axis_tdata[100:85];
                got.dropped    = m_axis_tdata[101];
                got.last       = m_axis_tlast;
                sb.check_word(got);
            end
            if (stall_left > 0) begin
                stall_left    <= stall_left - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                stall_left    <= gap_len();
            end
        end
    end

    // Watchdog: end the run if neither stream moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("multitouch_slot_frame_tracker_test failed");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Present one event word; valid stays up if the next word follows at once.
    task send_event(logic [3:0] kind, logic [31:0] value);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= value;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_event(kind, value);
        events_sent++;
    endtask

    // Hold the input until every predicted word is out, then let the block settle.
    task drain_frames();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task write_axes(logic [2:0] axes);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= axes;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_axes(axes);
    endtask

    function logic [31:0] axis_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return $urandom_range(0, 65535);
        return $urandom();
    endfunction

    function logic [31:0] id_value();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12) return $urandom_range(0, 400);
        if (r < 16) return -1;
        if (r < 18) return 32'd65536 + $urandom_range(0, 1000000);
        return $urandom();
    endfunction

    function logic [31:0] slot_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 8) return $urandom_range(0, 15);
        if (r < 9) return -$urandom_range(1, 100);
        return $urandom();
    endfunction

    // Mostly well-formed per-slot updates, with noise kinds and odd values mixed in.
    task random_events(int count);
        int stop_at;
        int r;
        stop_at = events_sent + count;
        while (events_sent < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 12)      send_event(mtsf_pkg::K_FRAME, $urandom());
            else if (r < 27) send_event(mtsf_pkg::K_SLOT, slot_value());
            else if (r < 42) send_event(mtsf_pkg::K_ID, id_value());
            else if (r < 55) send_event(mtsf_pkg::K_X, axis_value());
            else if (r < 68) send_event(mtsf_pkg::K_Y, axis_value());
            else if (r < 76) send_event(mtsf_pkg::K_MAJ, axis_value());
            else if (r < 84) send_event(mtsf_pkg::K_MIN, axis_value());
            else if (r < 92) send_event(mtsf_pkg::K_PRS, axis_value());
            else if (r < 96) send_event(4'($urandom_range(8, 15)), $urandom());
            else begin
                // full contact: land, place, shape
                send_event(mtsf_pkg::K_SLOT, $urandom_range(0, 15));
                send_event(mtsf_pkg::K_ID, $urandom_range(0, 65535));
                send_event(mtsf_pkg::K_X, axis_value());
                send_event(mtsf_pkg::K_Y, axis_value());
                send_event(mtsf_pkg::K_PRS, axis_value());
            end
        end
        send_event(mtsf_pkg::K_FRAME, '0);
    endtask

    initial begin
        sb = new();
        events_sent   = 0;
        steady        = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = 3'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        write_axes(3'd7);

        // Directed: clamps, saturation, id replace, stray lift, empty frame.
        send_event(mtsf_pkg::K_FRAME, '0);
        send_event(mtsf_pkg::K_SLOT, 32'h8000_0000);
        send_event(mtsf_pkg::K_X, 32'd1234);
        send_event(mtsf_pkg::K_ID, 32'h7FFF_FFFF);
        send_event(mtsf_pkg::K_X, 32'hFFFF_FFFF);
        send_event(mtsf_pkg::K_Y, 32'd70000);
        send_event(mtsf_pkg::K_MAJ, 32'd65535);
        send_event(mtsf_pkg::K_MIN, 32'h8000_0000);
        send_event(mtsf_pkg::K_PRS, 32'd300);
        send_event(mtsf_pkg::K_SLOT, 32'd100);
        send_event(mtsf_pkg::K_ID, 32'd7);
        send_event(mtsf_pkg::K_ID, 32'd9);
        send_event(K_IGNORED, 32'hA5A5_5A5A);
        send_event(K_RESERVED, 32'h5A5A_A5A5);
        send_event(mtsf_pkg::K_SLOT, 32'd3);
        send_event(mtsf_pkg::K_ID, 32'hFFFF_FFFF);
        send_event(mtsf_pkg::K_ID, 32'd42);
        send_event(mtsf_pkg::K_ID, 32'h8000_0000);
        send_event(mtsf_pkg::K_FRAME, '0);
        send_event(mtsf_pkg::K_SLOT, 32'd0);
        send_event(mtsf_pkg::K_X, 32'd0);
        send_event(mtsf_pkg::K_SLOT, 32'd15);
        send_event(mtsf_pkg::K_ID, 32'hFFFF_FFFF);
        send_event(mtsf_pkg::K_FRAME, '0);

        // Overflow both queues: one slot lands and lifts seventeen times.
        send_event(mtsf_pkg::K_SLOT, 32'd5);
        repeat (17) begin
            send_event(mtsf_pkg::K_ID, 32'd11);
            send_event(mtsf_pkg::K_ID, 32'hFFFF_FFFF);
        end
        send_event(mtsf_pkg::K_FRAME, '0);
        drain_frames();

        random_events(65);
        drain_frames();
        write_axes(3'd0);
        random_events(55);
        drain_frames();
        write_axes(3'd5);
        steady = 1'b1;
        random_events(50);
        drain_frames();
        steady = 1'b0;
        write_axes(3'd2);
        random_events(55);
        drain_frames();
        write_axes(3'($urandom_range(0, 7)));
        random_events(55);
        drain_frames();

        $display("Sent %0d events in %0d frames under five axis settings; checked %0d words.",
                 events_sent, sb.frames, sb.words_checked);
        $display("Covered slot clamps, id saturation, queue overflow and disabled axes.");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("multitouch_slot_frame_tracker_test passed");
        else
            $display("multitouch_slot_frame_tracker_test failed");
        $finish;
    end
endmodule
